@@ rtl/dmc_pkg.sv @@
// Shared constants and types of the direct-mapped cache.
package dmc_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 64;
    localparam int LANES      = 8;
    localparam int LANE_W     = 3;
    localparam int SIZE_W     = 2;
    localparam int CNT32_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int DEF_LINE_BYTES = 64;
    localparam int DEF_NUM_LINES  = 64;
    localparam int DEF_MEM_BYTES  = 65536;

    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT   = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_WB,
        S_RF,
        S_WRITE
    } state_t;

endpackage

@@ rtl/dmc_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/direct_mapped_cache_top.sv @@
// Direct-mapped cache with its backing memory, control sequencer and datapath.
// Each item is captured and its tag and data rows are read at the transfer in; S_EVAL then
// registers the result for hits, errors and no-allocate write misses, and a result held by
// out_stall holds the sequencer. A read miss registers its result in S_EVAL, then input stalls
// through the refill (S_RF), preceded by a dirty victim's write-back (S_WB) in write-back mode;
// a write-allocate miss registers its result in S_WRITE after them. Reset: a clearing pass
// (S_CLEAR) zeroes backing memory and tag entries; no item is taken during it.
module direct_mapped_cache_top #(
    parameter int LINE_BYTES = dmc_pkg::DEF_LINE_BYTES,
    parameter int NUM_LINES  = dmc_pkg::DEF_NUM_LINES,
    parameter int MEM_BYTES  = dmc_pkg::DEF_MEM_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item in
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [dmc_pkg::SIZE_W-1:0]        access_size,
    input  logic [dmc_pkg::ADDR_W-1:0]        address,
    input  logic [dmc_pkg::DATA_W-1:0]        write_data,
    // result out
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dmc_pkg::DATA_W-1:0]        read_data,
    output logic                              was_hit,
    output logic                              range_error,
    output logic [dmc_pkg::CNT32_W-1:0]       hit_count,
    output logic [dmc_pkg::CNT32_W-1:0]       miss_count,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W   = dmc_pkg::ADDR_W;
    localparam int LANES    = dmc_pkg::LANES;
    localparam int LANE_W   = dmc_pkg::LANE_W;
    localparam int OFF_W    = $clog2(LINE_BYTES);
    localparam int IDX_W    = $clog2(NUM_LINES);
    localparam int TAG_W    = ADDR_W - OFF_W;
    localparam int TE_W     = TAG_W + 2;
    localparam int RPL      = LINE_BYTES / LANES;
    localparam int LD_AW    = IDX_W + OFF_W;
    localparam int LD_RW    = LD_AW - LANE_W;
    localparam int LD_ROWS  = NUM_LINES * RPL;
    localparam int MEM_AW   = $clog2(MEM_BYTES);
    localparam int MEM_RW   = MEM_AW - LANE_W;
    localparam int MEM_ROWS = MEM_BYTES / LANES;
    localparam int CLR_N    = (MEM_ROWS > NUM_LINES) ? MEM_ROWS : NUM_LINES;
    localparam int CNT_W    = $clog2(CLR_N + 1);
    localparam int LIM_W    = ($clog2(MEM_BYTES + 1) > dmc_pkg::CFG_DATA_W) ?
                              $clog2(MEM_BYTES + 1) : dmc_pkg::CFG_DATA_W;

    // configuration
    logic                            wb_reg;
    logic                            wa_reg;
    logic [dmc_pkg::CFG_DATA_W-1:0]  limit_reg;

    // sequencer
    dmc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // captured item
    logic                          op_reg;
    logic [dmc_pkg::SIZE_W-1:0]    size_reg;
    logic [ADDR_W-1:0]             addr_reg;
    logic [dmc_pkg::DATA_W-1:0]    wdata_reg;

    // counters and result register
    logic [dmc_pkg::CNT32_W-1:0] hits_reg, hits_next;
    logic [dmc_pkg::CNT32_W-1:0] misses_reg, misses_next;
    logic                        out_valid_reg, out_valid_next;
    logic [dmc_pkg::DATA_W-1:0]  read_data_reg, read_data_next;
    logic                        was_hit_reg, was_hit_next;
    logic                        range_error_reg, range_error_next;

    logic accept;
    logic go;

    // tag store: {valid, dirty, block}
    logic             tag_we;
    logic [IDX_W-1:0] tag_waddr;
    logic [TE_W-1:0]  tag_wdata;
    logic [TE_W-1:0]  tag_rd;
    logic             tag_upd;
    logic [TE_W-1:0]  tag_upd_data;
    logic             tag_clr;

    logic             t_valid;
    logic             t_dirty;
    logic [TAG_W-1:0] t_block;

    logic [IDX_W-1:0] idx_in;
    logic [IDX_W-1:0] idx_r;
    logic [TAG_W-1:0] block_r;
    logic [OFF_W-1:0] off_r;
    logic [3:0]       sz;

    logic [LIM_W-1:0] limit_eff;
    logic [LIM_W-1:0] end_addr;
    logic [OFF_W:0]   end_off;
    logic             err;
    logic             hit;
    logic             need_wb;

    // per-lane memory ports
    logic                ld_we    [LANES];
    logic [LD_RW-1:0]    ld_waddr [LANES];
    logic [7:0]          ld_wdata [LANES];
    logic                ld_re;
    logic [LD_RW-1:0]    ld_raddr [LANES];
    logic [7:0]          ld_rd    [LANES];

    logic                mem_we    [LANES];
    logic [MEM_RW-1:0]   mem_waddr [LANES];
    logic [7:0]          mem_wdata [LANES];
    logic                mem_re;
    logic [MEM_RW-1:0]   mem_raddr [LANES];
    logic [7:0]          mem_rd    [LANES];

    logic [7:0]          wbyte   [LANES];
    logic                lane_en [LANES];

    logic [LD_RW-1:0]    sweep_lrow;
    logic [LD_RW-1:0]    sweep_lrow_prev;
    logic [MEM_RW-1:0]   blk_mrow;
    logic [MEM_RW-1:0]   vic_mrow;
    logic [CNT_W-1:0]    cnt_prev;

    logic [dmc_pkg::DATA_W-1:0] line_asm;
    logic [dmc_pkg::DATA_W-1:0] mem_asm;

    // control flags from the sequencer
    logic wr_line;
    logic wr_mem;
    logic mem_clr;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != dmc_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    // the result register can take a new result this cycle
    assign go        = !out_valid_reg || !out_stall;

    assign idx_in  = IDX_W'(address[ADDR_W-1:OFF_W]);
    assign idx_r   = IDX_W'(addr_reg[ADDR_W-1:OFF_W]);
    assign block_r = addr_reg[ADDR_W-1:OFF_W];
    assign off_r   = addr_reg[OFF_W-1:0];
    assign sz      = 4'd1 << size_reg;

    assign t_valid = tag_rd[TE_W-1];
    assign t_dirty = tag_rd[TE_W-2];
    assign t_block = tag_rd[TAG_W-1:0];

    // range checks: the limit saturates at the memory size
    assign limit_eff = (LIM_W'(limit_reg) > LIM_W'(MEM_BYTES)) ?
                       LIM_W'(MEM_BYTES) : LIM_W'(limit_reg);
    assign end_addr  = LIM_W'(addr_reg) + LIM_W'(sz);
    assign end_off   = {1'b0, off_r} + (OFF_W+1)'(sz);
    assign err       = (end_addr > limit_eff) || (end_off > (OFF_W+1)'(LINE_BYTES));
    assign hit       = t_valid && (t_block == block_r);
    assign need_wb   = t_valid && t_dirty && wb_reg;

    // sweep addressing: whole rows of the line and of the block in memory
    assign cnt_prev        = cnt_reg - 1'b1;
    assign sweep_lrow      = LD_RW'({idx_r, OFF_W'(0)} >> LANE_W) + LD_RW'(cnt_reg);
    assign sweep_lrow_prev = LD_RW'({idx_r, OFF_W'(0)} >> LANE_W) + LD_RW'(cnt_prev);
    assign blk_mrow        = MEM_RW'({block_r, OFF_W'(0)} >> LANE_W);
    assign vic_mrow        = MEM_RW'({t_block, OFF_W'(0)} >> LANE_W);

    // byte lanes: lane b holds bytes whose address is b modulo 8, so an
    // unaligned access touches each lane at most once
    for (genvar b = 0; b < LANES; b++)
    begin : g_lane
        logic             inc_in;
        logic             inc_r;
        logic [LANE_W-1:0] j;
        logic [LD_RW-1:0]  in_lrow;
        logic [LD_RW-1:0]  r_lrow;
        logic [MEM_RW-1:0] in_mrow;
        logic [MEM_RW-1:0] r_mrow;

        assign inc_in  = LANE_W'(b) < address[LANE_W-1:0];
        assign inc_r   = LANE_W'(b) < addr_reg[LANE_W-1:0];
        assign in_lrow = LD_RW'({idx_in, address[OFF_W-1:0]} >> LANE_W) + LD_RW'(inc_in);
        assign r_lrow  = LD_RW'({idx_r, off_r} >> LANE_W) + LD_RW'(inc_r);
        assign in_mrow = MEM_RW'(address >> LANE_W) + MEM_RW'(inc_in);
        assign r_mrow  = MEM_RW'(addr_reg >> LANE_W) + MEM_RW'(inc_r);

        assign j          = LANE_W'(b) - addr_reg[LANE_W-1:0];
        assign wbyte[b]   = wdata_reg[8*j +: 8];
        assign lane_en[b] = {1'b0, j} < sz;

        // line data lane
        assign ld_raddr[b] = accept ? in_lrow : sweep_lrow;
        assign ld_we[b]    = ((state_reg == dmc_pkg::S_RF) && (cnt_reg != '0)) ||
                             (wr_line && lane_en[b]);
        assign ld_waddr[b] = (state_reg == dmc_pkg::S_RF) ? sweep_lrow_prev : r_lrow;
        assign ld_wdata[b] = (state_reg == dmc_pkg::S_RF) ? mem_rd[b] : wbyte[b];

        // backing memory lane
        assign mem_raddr[b] = accept ? in_mrow : (blk_mrow + MEM_RW'(cnt_reg));
        assign mem_we[b]    = mem_clr ||
                              ((state_reg == dmc_pkg::S_WB) && (cnt_reg != '0)) ||
                              (wr_mem && lane_en[b]);
        assign mem_waddr[b] = mem_clr ? MEM_RW'(cnt_reg) :
                              (state_reg == dmc_pkg::S_WB) ?
                              (vic_mrow + MEM_RW'(cnt_prev)) : r_mrow;
        assign mem_wdata[b] = mem_clr ? 8'h00 :
                              (state_reg == dmc_pkg::S_WB) ? ld_rd[b] : wbyte[b];

        dmc_ram #(
            .WIDTH (8),
            .DEPTH (LD_ROWS)
        ) u_line (
            .clk   (clk),
            .we    (ld_we[b]),
            .waddr (ld_waddr[b]),
            .wdata (ld_wdata[b]),
            .re    (ld_re),
            .raddr (ld_raddr[b]),
            .rdata (ld_rd[b])
        );

        dmc_ram #(
            .WIDTH (8),
            .DEPTH (MEM_ROWS)
        ) u_mem (
            .clk   (clk),
            .we    (mem_we[b]),
            .waddr (mem_waddr[b]),
            .wdata (mem_wdata[b]),
            .re    (mem_re),
            .raddr (mem_raddr[b]),
            .rdata (mem_rd[b])
        );
    end

    assign ld_re  = accept || ((state_reg == dmc_pkg::S_WB) && (cnt_reg < CNT_W'(RPL)));
    assign mem_re = accept || ((state_reg == dmc_pkg::S_RF) && (cnt_reg < CNT_W'(RPL)));

    // tag store
    assign tag_we    = tag_clr || tag_upd;
    assign tag_waddr = tag_clr ? IDX_W'(cnt_reg) : idx_r;
    assign tag_wdata = tag_clr ? '0 : tag_upd_data;

    dmc_ram #(
        .WIDTH (TE_W),
        .DEPTH (NUM_LINES)
    ) u_tag (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (accept),
        .raddr (idx_in),
        .rdata (tag_rd)
    );

    // gather the access bytes from the lanes, low byte first
    always_comb
    begin
        logic [LANE_W-1:0] k;
        line_asm = '0;
        mem_asm  = '0;
        for (int i = 0; i < LANES; i++)
        begin
            k = LANE_W'(i) + addr_reg[LANE_W-1:0];
            if (4'(i) < sz)
            begin
                line_asm[8*i +: 8] = ld_rd[k];
                mem_asm[8*i +: 8]  = mem_rd[k];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        hits_next        = hits_reg;
        misses_next      = misses_reg;
        out_valid_next   = out_valid_reg && out_stall;
        read_data_next   = read_data_reg;
        was_hit_next     = was_hit_reg;
        range_error_next = range_error_reg;
        wr_line          = 1'b0;
        wr_mem           = 1'b0;
        mem_clr          = 1'b0;
        tag_clr          = 1'b0;
        tag_upd          = 1'b0;
        tag_upd_data     = {1'b1, wb_reg, block_r};

        case (state_reg)
            dmc_pkg::S_CLEAR:
            begin
                mem_clr = 1'b1;
                tag_clr = cnt_reg < CNT_W'(NUM_LINES);
                if (cnt_reg == CNT_W'(CLR_N - 1))
                begin
                    cnt_next   = '0;
                    state_next = dmc_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            dmc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = dmc_pkg::S_EVAL;
                end
            end

            dmc_pkg::S_EVAL:
            begin
                if (err)
                begin
                    if (go)
                    begin
                        out_valid_next   = 1'b1;
                        read_data_next   = '0;
                        was_hit_next     = 1'b0;
                        range_error_next = 1'b1;
                        state_next       = dmc_pkg::S_IDLE;
                    end
                end
                else if (op_reg == dmc_pkg::OP_READ)
                begin
                    if (go)
                    begin
                        out_valid_next   = 1'b1;
                        was_hit_next     = hit;
                        range_error_next = 1'b0;
                        if (hit)
                        begin
                            read_data_next = line_asm;
                            hits_next      = hits_reg + 1'b1;
                            state_next     = dmc_pkg::S_IDLE;
                        end
                        else
                        begin
                            // memory holds this block's current data, as a miss means no copy of it is cached
                            read_data_next = mem_asm;
                            misses_next    = misses_reg + 1'b1;
                            cnt_next       = '0;
                            state_next     = need_wb ? dmc_pkg::S_WB : dmc_pkg::S_RF;
                        end
                    end
                end
                else if (hit)
                begin
                    if (go)
                    begin
                        wr_line          = 1'b1;
                        wr_mem           = !wb_reg;
                        tag_upd          = 1'b1;
                        out_valid_next   = 1'b1;
                        read_data_next   = '0;
                        was_hit_next     = 1'b1;
                        range_error_next = 1'b0;
                        state_next       = dmc_pkg::S_IDLE;
                    end
                end
                else if (!wa_reg)
                begin
                    if (go)
                    begin
                        wr_mem           = 1'b1;
                        out_valid_next   = 1'b1;
                        read_data_next   = '0;
                        was_hit_next     = 1'b0;
                        range_error_next = 1'b0;
                        state_next       = dmc_pkg::S_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = need_wb ? dmc_pkg::S_WB : dmc_pkg::S_RF;
                end
            end

            dmc_pkg::S_WB:
            begin
                // read row n, write row n-1 to memory
                if (cnt_reg == CNT_W'(RPL))
                begin
                    cnt_next   = '0;
                    state_next = dmc_pkg::S_RF;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            dmc_pkg::S_RF:
            begin
                if (cnt_reg == CNT_W'(RPL))
                begin
                    tag_upd      = 1'b1;
                    tag_upd_data = {1'b1, 1'b0, block_r};
                    cnt_next     = '0;
                    state_next   = (op_reg == dmc_pkg::OP_WRITE) ?
                                   dmc_pkg::S_WRITE : dmc_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            dmc_pkg::S_WRITE:
            begin
                if (go)
                begin
                    wr_line          = 1'b1;
                    wr_mem           = !wb_reg;
                    tag_upd          = 1'b1;
                    out_valid_next   = 1'b1;
                    read_data_next   = '0;
                    was_hit_next     = 1'b0;
                    range_error_next = 1'b0;
                    state_next       = dmc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = dmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmc_pkg::S_CLEAR;
            cnt_reg       <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
            wb_reg        <= 1'b1;
            wa_reg        <= 1'b1;
            limit_reg     <= dmc_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dmc_pkg::CFG_WRITE_BACK:  wb_reg    <= cfg_data[0];
                    dmc_pkg::CFG_WRITE_ALLOC: wa_reg    <= cfg_data[0];
                    dmc_pkg::CFG_MEM_LIMIT:   limit_reg <= cfg_data;
                    default:                  ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            size_reg  <= access_size;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        read_data_reg   <= read_data_next;
        was_hit_reg     <= was_hit_next;
        range_error_reg <= range_error_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;
    assign was_hit     = was_hit_reg;
    assign range_error = range_error_reg;
    assign hit_count   = hits_reg;
    assign miss_count  = misses_reg;

endmodule

@@ rtl/dmc_checker.sv @@
// Port-level checks of the cache result channel, bound to the top level.
module dmc_assertions (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [dmc_pkg::DATA_W-1:0]    read_data,
    input logic                          was_hit,
    input logic                          range_error,
    input logic [dmc_pkg::CNT32_W-1:0]   hit_count,
    input logic [dmc_pkg::CNT32_W-1:0]   miss_count
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> (read_data == '0) && !was_hit)
        else $error("error result carries data or hit");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> $stable(hit_count) && $stable(miss_count))
        else $error("counter moved without a result");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((hit_count == $past(hit_count)) || (hit_count == $past(hit_count) + 32'd1)) &&
        ((miss_count == $past(miss_count)) || (miss_count == $past(miss_count) + 32'd1)))
        else $error("counter jumped");

endmodule

bind direct_mapped_cache_top dmc_assertions u_dmc_assertions (.*);

@@ verif/dmc_checker.sv @@
// Checker for the direct-mapped cache: mirrors cache state, predicts and compares results.
module dmc_checker
    import dmc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     op,
    input  logic [SIZE_W-1:0]        access_size,
    input  logic [ADDR_W-1:0]        address,
    input  logic [DATA_W-1:0]        write_data,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [DATA_W-1:0]        read_data,
    input  logic                     was_hit,
    input  logic                     range_error,
    input  logic [CNT32_W-1:0]       hit_count,
    input  logic [CNT32_W-1:0]       miss_count,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       errors,
    output int                       pending,
    output int                       results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LB = DEF_LINE_BYTES;
    localparam int NL = DEF_NUM_LINES;
    localparam int MB = DEF_MEM_BYTES;

    typedef struct packed {
        logic [DATA_W-1:0]  rdata;
        logic               hit;
        logic               err;
        logic [CNT32_W-1:0] hits;
        logic [CNT32_W-1:0] misses;
    } cache_result_t;

    logic                  m_wb;
    logic                  m_alloc;
    logic [CFG_DATA_W-1:0] m_limit;
    logic                  m_valid [NL];
    logic                  m_dirty [NL];
    int                    m_tag   [NL];
    logic [7:0]            m_line  [NL*LB];
    logic [7:0]            m_mem   [MB];
    logic [CNT32_W-1:0]    m_hits;
    logic [CNT32_W-1:0]    m_misses;

    cache_result_t expected_results[$];

    task automatic fill_line(input int idx, input int blk);
        if (m_valid[idx] && m_dirty[idx] && m_tag[idx] != blk && m_wb)
            for (int i = 0; i < LB; i++)
                m_mem[(m_tag[idx]*LB + i) % MB] = m_line[idx*LB + i];
        m_valid[idx] = 1'b1;
        m_dirty[idx] = 1'b0;
        m_tag[idx]   = blk;
        for (int i = 0; i < LB; i++)
            m_line[idx*LB + i] = m_mem[(blk*LB + i) % MB];
    endtask

    task automatic predict_access(input logic wr, input logic [SIZE_W-1:0] sz,
                                  input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] wd);
        cache_result_t r;
        int nb, lim, off, blk, idx;
        nb  = 1 << sz;
        lim = (m_limit > MB) ? MB : int'(m_limit);
        off = a % LB;
        blk = a / LB;
        idx = blk % NL;
        r = '0;
        if (int'(a) + nb > lim || off + nb > LB) begin
            r.err = 1'b1;
        end else begin
            r.hit = m_valid[idx] && m_tag[idx] == blk;
            if (wr == OP_READ) begin
                if (r.hit) begin
                    m_hits++;
                    for (int i = 0; i < nb; i++)
                        r.rdata[8*i +: 8] = m_line[idx*LB + off + i];
                end else begin
                    m_misses++;
                    for (int i = 0; i < nb; i++)
                        r.rdata[8*i +: 8] = m_mem[a + i];
                    fill_line(idx, blk);
                end
            end else if (!r.hit && !m_alloc) begin
                for (int i = 0; i < nb; i++)
                    m_mem[a + i] = wd[8*i +: 8];
            end else begin
                if (!r.hit)
                    fill_line(idx, blk);
                for (int i = 0; i < nb; i++)
                    m_line[idx*LB + off + i] = wd[8*i +: 8];
                if (m_wb) begin
                    m_dirty[idx] = 1'b1;
                end else begin
                    for (int i = 0; i < nb; i++)
                        m_mem[a + i] = wd[8*i +: 8];
                    m_dirty[idx] = 1'b0;
                end
            end
        end
        r.hits   = m_hits;
        r.misses = m_misses;
        expected_results.push_back(r);
    endtask

    initial
    begin
        m_wb = 1'b1; m_alloc = 1'b1; m_limit = LIMIT_RESET;
        m_hits = '0; m_misses = '0;
        foreach (m_valid[i]) begin m_valid[i] = 1'b0; m_dirty[i] = 1'b0; m_tag[i] = 0; end
        foreach (m_line[i]) m_line[i] = '0;
        foreach (m_mem[i]) m_mem[i] = '0;
        errors = 0;
        results_seen = 0;
    end

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        cache_result_t got, exp_r;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WRITE_BACK:  m_wb    = cfg_data[0];
                    CFG_WRITE_ALLOC: m_alloc = cfg_data[0];
                    CFG_MEM_LIMIT:   m_limit = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_access(op, access_size, address, write_data);
            if (out_valid && !out_stall) begin
                got = '{read_data, was_hit, range_error, hit_count, miss_count};
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: result differs, expected %p, actual %p",
                                 $time, exp_r, got);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

@@ verif/direct_mapped_cache_top_tb.sv @@
// Top of the direct-mapped cache testbench: clock, reset, stimulus and verdict.
module direct_mapped_cache_top_tb;
    import dmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  op = OP_READ;
    logic [SIZE_W-1:0]     access_size = '0;
    logic [ADDR_W-1:0]     address = '0;
    logic [DATA_W-1:0]     write_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DATA_W-1:0]     read_data;
    logic                  was_hit;
    logic                  range_error;
    logic [CNT32_W-1:0]    hit_count;
    logic [CNT32_W-1:0]    miss_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors, pending, results_seen;
    int                    accesses_sent = 0;

    always #6 clk = ~clk;

    direct_mapped_cache_top dut (.*);

    dmc_checker checker_i (.*);

    // Receiver back-pressure: random stall length per result, with calm stretches.
    initial
    begin
        int n;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0) begin
                n = 0;
            end else begin
                n = $urandom_range(0, 6);
            end
            if (n != 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            while (!(out_valid && !out_stall)) @(posedge clk);
        end
    end

    // One access transfer, after a random gap drawn beforehand. Valid stays high
    // after the transfer until the next gap or drain decides, so back-to-back items
    // never see two drives of valid in one step.
    task automatic send_access(input logic wr, input logic [SIZE_W-1:0] sz,
                               input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] wd);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= wr;
        access_size <= sz;
        address     <= a;
        write_data  <= wd;
        do @(posedge clk); while (in_stall);
        accesses_sent++;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic wait_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Register writes happen only with the cache drained plus a margin for misses.
    task automatic drain_and_settle();
        wait_empty();
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Address kept aligned to the access size most of the time so it stays in one line;
    // a small share is fully random to hit line crossings and limit errors.
    task automatic random_access(input int pool_blocks);
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] a;
        int blk;
        sz = SIZE_W'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) begin
            a = ADDR_W'($urandom);
        end else begin
            // a few blocks sharing cache indexes, so hits, conflicts and victims all occur
            blk = ($urandom_range(0, pool_blocks - 1) * 64 + $urandom_range(0, 3))
                  % 1024;
            a = ADDR_W'(blk * 64 + ($urandom_range(0, 63) & ~((1 << sz) - 1)));
        end
        send_access(1'($urandom_range(0, 1)), sz, a, rand64());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads of fresh memory, writes of every size, then the same data read back.
        send_access(OP_READ,  2'd0, 16'h0000, '0);
        send_access(OP_WRITE, 2'd3, 16'h0008, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(OP_READ,  2'd3, 16'h0008, '0);
        send_access(OP_WRITE, 2'd0, 16'h0001, 64'h0000_0000_0000_00A5);
        send_access(OP_WRITE, 2'd1, 16'h0002, 64'h1234_5678_9ABC_BEEF);
        send_access(OP_WRITE, 2'd2, 16'h0004, 64'hFFFF_FFFF_CAFE_F00D);
        send_access(OP_READ,  2'd3, 16'h0000, '0);
        // conflict on line 0: dirty victim written back, then reread
        send_access(OP_READ,  2'd2, 16'h1000, '0);
        send_access(OP_READ,  2'd3, 16'h0000, '0);
        // line crossing and top of memory
        send_access(OP_READ,  2'd3, 16'h003C, '0);
        send_access(OP_WRITE, 2'd1, 16'h003F, rand64());
        send_access(OP_WRITE, 2'd3, 16'hFFF8, 64'h8000_0000_0000_0001);
        send_access(OP_READ,  2'd3, 16'hFFF8, '0);
        send_access(OP_READ,  2'd0, 16'hFFFF, '0);
        send_access(OP_READ,  2'd3, 16'hFFFC, '0);
        drain_and_settle();

        // Write-through, no-allocate: memory written at the address, dirty data dropped.
        write_reg(CFG_WRITE_BACK, 17'd0);
        write_reg(CFG_WRITE_ALLOC, 17'd0);
        send_access(OP_WRITE, 2'd2, 16'h2014, 64'h0000_0000_1357_9BDF);
        send_access(OP_READ,  2'd2, 16'h2014, '0);
        send_access(OP_WRITE, 2'd1, 16'h2016, 64'h0000_0000_0000_4242);
        send_access(OP_READ,  2'd3, 16'h2010, '0);
        send_access(OP_READ,  2'd3, 16'hFFF8, '0);
        drain_and_settle();

        // A small and a tiny limit, plus a limit above memory size.
        write_reg(CFG_MEM_LIMIT, 17'd8);
        send_access(OP_READ,  2'd3, 16'h0000, '0);
        send_access(OP_READ,  2'd0, 16'h0008, '0);
        drain_and_settle();
        write_reg(CFG_MEM_LIMIT, 17'd3);
        send_access(OP_READ,  2'd1, 16'h0001, '0);
        send_access(OP_READ,  2'd2, 16'h0000, '0);
        drain_and_settle();
        write_reg(CFG_MEM_LIMIT, 17'h1FFFF);
        send_access(OP_READ,  2'd3, 16'hFFF8, '0);
        drain_and_settle();

        // Random phases across all four policy combinations and varied limits.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_WRITE_BACK, CFG_DATA_W'(ph[0]));
            write_reg(CFG_WRITE_ALLOC, CFG_DATA_W'(ph[1]));
            case (ph)
                3:       write_reg(CFG_MEM_LIMIT, CFG_DATA_W'($urandom_range(8, 65535)));
                5:       write_reg(CFG_MEM_LIMIT, 17'd65536);
                6:       write_reg(CFG_MEM_LIMIT, CFG_DATA_W'($urandom_range(65537, 131071)));
                default: write_reg(CFG_MEM_LIMIT, LIMIT_RESET);
            endcase
            for (int k = 0; k < 62; k++) begin
                random_access((ph % 2 == 0) ? 3 : 16);
                // let the pipe empty once mid-phase
                if (k == 30)
                    wait_empty();
            end
            drain_and_settle();
        end

        $display("Sent %0d accesses, checked %0d results over write-back/through,",
                 accesses_sent, results_seen);
        $display("allocate/no-allocate, several memory limits, hits, misses and errors.");
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: clearing pass, slow misses with stalls, all generously covered.
    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dmc_pkg.sv
rtl/dmc_ram.sv
rtl/direct_mapped_cache_top.sv
rtl/dmc_checker.sv
verif/dmc_checker.sv
verif/direct_mapped_cache_top_tb.sv
